>>> rtl/core/u8s_pkg.sv
`timescale 1ns / 1ps

package u8s_pkg;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // One finished sequence, ready to be played out byte by byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            replaced;
  } job_t;

endpackage

>>> rtl/core/u8s_front.sv
`timescale 1ns / 1ps

module u8s_front import u8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       job_push,
  output job_t       job
);

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0]      need_r, need_nxt;

  logic [3:0][7:0] seq;
  logic [1:0]      last;
  logic            ok;
  logic            done;

  function automatic logic [1:0] follow_count(input logic [7:0] b);
    logic [1:0] r;
    if (b[7:4] == 4'hF) r = 2'd3;
    else if (b[7:5] == 3'b111) r = 2'd2;
    else if (b[7:6] == 2'b11) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

  function automatic logic is_cont(input logic [7:0] x);
    return x[7:6] == 2'b10;
  endfunction

  function automatic logic seq_ok(input logic [3:0][7:0] s, input logic [1:0] n);
    logic r;
    logic [7:0] a;
    a = s[0];
    r = 1'b0;
    case (n)
      2'd0: r = (a >= 8'h20 && a < 8'h7F) || a == 8'h09 || a == 8'h0A || a == 8'h0D;
      2'd1: r = a >= 8'hC2 && a <= 8'hDF && is_cont(s[1]) && !(a == 8'hC2 && s[1] <= 8'h84);
      2'd2: begin
        r = is_cont(s[1]) && is_cont(s[2]);
        if (a == 8'hE0) begin
          if (s[1] < 8'hA0) r = 1'b0;
        end else if (a == 8'hED) begin
          if (s[1] > 8'h9F) r = 1'b0;
        end else if (a < 8'hE1 || a > 8'hEF) begin
          r = 1'b0;
        end
        if (a == 8'hEF && s[1] == 8'hB7 && s[2] >= 8'h90 && s[2] <= 8'hAF) r = 1'b0;
        if (a == 8'hEF && s[1] == 8'hBF && s[2] >= 8'hBE) r = 1'b0;
      end
      default: begin
        r = is_cont(s[1]) && is_cont(s[2]) && is_cont(s[3]);
        if (a == 8'hF0) begin
          if (s[1] < 8'h90) r = 1'b0;
        end else if (a == 8'hF4) begin
          if (s[1] > 8'h8F) r = 1'b0;
        end else if (a < 8'hF1 || a > 8'hF3) begin
          r = 1'b0;
        end
        if (s[1][3:0] == 4'hF && s[2] == 8'hBF && s[3] >= 8'hBE) r = 1'b0;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    if (need_r == 2'd0) begin
      seq  = {8'h00, 8'h00, 8'h00, data_byte};
      last = 2'd0;
    end else begin
      seq[0] = held_r[0];
      seq[1] = (cnt_r == 2'd1) ? data_byte : held_r[1];
      seq[2] = (cnt_r == 2'd2) ? data_byte : held_r[2];
      seq[3] = data_byte;
      last   = cnt_r;
    end
    ok = seq_ok(seq, last);

    if (ok) begin
      job.bytes    = seq;
      job.last_idx = last;
      job.replaced = 1'b0;
    end else begin
      job.bytes    = {8'h00, REPL_B2, REPL_B1, REPL_B0};
      job.last_idx = 2'd2;
      job.replaced = 1'b1;
    end
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    need_nxt = need_r;
    done     = 1'b0;
    if (accept) begin
      if (need_r == 2'd0) begin
        if (data_byte != 8'h00) begin
          if (follow_count(data_byte) == 2'd0) begin
            done = 1'b1;
          end else begin
            held_nxt[0] = data_byte;
            cnt_nxt     = 2'd1;
            need_nxt    = follow_count(data_byte);
          end
        end
      end else if (need_r > 2'd1) begin
        held_nxt[cnt_r] = data_byte;
        cnt_nxt         = cnt_r + 2'd1;
        need_nxt        = need_r - 2'd1;
      end else begin
        done     = 1'b1;
        cnt_nxt  = 2'd0;
        need_nxt = 2'd0;
      end
    end
  end

  assign job_push = done;

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      need_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      need_r <= need_nxt;
    end
  end

endmodule

>>> rtl/core/u8s_fifo.sv
`timescale 1ns / 1ps

module u8s_fifo import u8s_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  output logic valid,
  output job_t rd_job,
  input  logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign valid   = count_r != '0;
  assign rd_job  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/u8s_back.sv
`timescale 1ns / 1ps

module u8s_back import u8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       replaced,
  output logic       last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       repl_r, repl_nxt;
  logic       last_r, last_nxt;
  logic       load, at_last;

  assign load    = job_valid && (!valid_r || pop);
  assign at_last = idx_r == job.last_idx;
  assign job_pop = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    repl_nxt  = repl_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = job.bytes[idx_r];
      repl_nxt  = job.replaced;
      last_nxt  = at_last;
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    repl_r <= repl_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign empty       = !valid_r;
  assign out_byte    = byte_r;
  assign replaced    = repl_r;
  assign last_of_run = last_r;

endmodule

>>> rtl/core/utf8_xml_char_sanitizer.sv
`timescale 1ns / 1ps
// UTF-8 / XML character sanitizer.
// Input channel: present a raw byte on in_data_byte with in_push high; it is
// taken at any rising edge where in_full is low. One byte per cycle.
// Result channel: while out_empty is low, out_byte, out_replaced and
// out_last_of_run show the oldest result byte; out_pop takes it.
// Each byte that completes a sequence produces 1 to 4 output bytes (the
// sequence as received, or EF BF BD marked replaced); gathering bytes and
// NUL leads produce none. out_last_of_run marks the final byte of a run.
// The completing byte's job is written into the queue and then loaded into
// the output register, which shows the first result byte. With out_pop held
// high the output side drains one byte per cycle, so sustained throughput is
// one input byte per cycle whenever each input byte yields at most one output
// byte; expansion is absorbed by the job queue of QUEUE_DEPTH finished
// sequences between classifier and emitter. When the receiver stalls, the
// output register holds, the queue fills and in_full rises; no byte is lost.
// Reset (rst_n low at an edge) drops any partly gathered sequence, empties
// the queue and the output register.
module utf8_xml_char_sanitizer import u8s_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_replaced,
  output logic       out_last_of_run
);

  logic accept;
  logic job_push, job_valid, job_pop;
  job_t wr_job, rd_job;

  assign accept = in_push && !in_full;

  u8s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .job_push  (job_push),
    .job       (wr_job)
  );

  u8s_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (wr_job),
    .full   (in_full),
    .valid  (job_valid),
    .rd_job (rd_job),
    .pop    (job_pop)
  );

  u8s_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job         (rd_job),
    .job_pop     (job_pop),
    .empty       (out_empty),
    .pop         (out_pop),
    .out_byte    (out_byte),
    .replaced    (out_replaced),
    .last_of_run (out_last_of_run)
  );

endmodule
